// ----- src/ps2_mouse_packet_and_click_events_unit_macros.svh -----
// ----------------------------------------------------------------------------
// PS/2 mouse packet unit: assertion macros
// Shared concurrent assertion forms, reset-qualified on the synchronous reset.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_AND_CLICK_EVENTS_UNIT_MACROS_SVH
`define PS2_MOUSE_PACKET_AND_CLICK_EVENTS_UNIT_MACROS_SVH

// same-cycle implication
`define PS2MCE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ps2mce assertion failed");

// next-cycle implication
`define PS2MCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ps2mce assertion failed");

`endif

// ----- src/ps2mce_pkg.sv -----
// ----------------------------------------------------------------------------
// ps2mce_pkg
// Types and constants shared by the PS/2 mouse packet and click event unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mce_pkg;

  localparam int COORD_BITS = 11;
  localparam int TICK_BITS  = 32;
  localparam int WIN_BITS   = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_X_LIMIT       = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Y_LIMIT       = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DCLICK_WINDOW = 2'd2;

  localparam logic [COORD_BITS-1:0] WIDTH_RESET  = 11'd800;
  localparam logic [COORD_BITS-1:0] HEIGHT_RESET = 11'd600;
  localparam logic [WIN_BITS-1:0]   WINDOW_RESET = 16'd30;
  localparam logic [COORD_BITS-1:0] POS_X_RESET  = 11'd400;
  localparam logic [COORD_BITS-1:0] POS_Y_RESET  = 11'd300;

  // header byte bits
  localparam int HDR_LEFT  = 0;
  localparam int HDR_RIGHT = 1;
  localparam int HDR_MID   = 2;
  localparam int HDR_SYNC  = 3;
  localparam int HDR_XSIGN = 4;
  localparam int HDR_YSIGN = 5;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_LEFT   = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_DRAG   = 3'd3,
    EV_RIGHT  = 3'd4
  } event_t;

  typedef struct packed {
    logic                 byte_ready;
    logic [7:0]           data_byte;
    logic [TICK_BITS-1:0] tick_now;
  } in_item_t;

  typedef struct packed {
    event_t                event_code;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
  } out_item_t;

  // one complete packet, already sign extended, Y already negated
  typedef struct packed {
    logic                 left;
    logic                 right;
    logic signed [8:0]    dx;
    logic signed [9:0]    dy;
    logic [TICK_BITS-1:0] tick;
  } pkt_t;

endpackage

`default_nettype wire

// ----- src/ps2mce_front.sv -----
// ----------------------------------------------------------------------------
// ps2mce_front
// Byte framing: collects header, X and Y bytes and emits one packet record.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mce_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  ps2mce_pkg::in_item_t in_item,
  output logic                 pkt_valid,
  input  wire                  pkt_ready,
  output ps2mce_pkg::pkt_t     pkt
);
  import ps2mce_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_X      = 2'd1,
    PH_Y      = 2'd2
  } phase_t;

  phase_t            phase;
  logic              left_in_packet;
  logic              right_in_packet;
  logic              x_negative;
  logic              y_negative;
  logic signed [8:0] x_delta;

  logic       take;
  logic [7:0] b;
  logic       hdr_ok;

  assign b      = in_item.data_byte;
  assign hdr_ok = b[HDR_SYNC] && !b[HDR_MID];
  // only the Y byte needs queue space
  assign in_ready  = pkt_ready || (phase != PH_Y);
  assign take      = in_valid && in_ready;
  assign pkt_valid = take && in_item.byte_ready && (phase == PH_Y);

  always_comb begin
    pkt.left  = left_in_packet;
    pkt.right = right_in_packet;
    pkt.dx    = x_delta;
    // sign extend to 10 bits first so that -(-256) stays representable
    pkt.dy    = -$signed({y_negative, y_negative, b});
    pkt.tick  = in_item.tick_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      left_in_packet  <= 1'b0;
      right_in_packet <= 1'b0;
      x_negative      <= 1'b0;
      y_negative      <= 1'b0;
      x_delta         <= '0;
    end else if (take) begin
      if (!in_item.byte_ready) begin
        phase <= PH_HEADER;
      end else begin
        case (phase)
          PH_X: begin
            x_delta <= $signed({x_negative, b});
            phase   <= PH_Y;
          end
          PH_Y: begin
            phase <= PH_HEADER;
          end
          default: begin
            phase <= PH_HEADER;
            if (hdr_ok) begin
              left_in_packet  <= b[HDR_LEFT];
              right_in_packet <= b[HDR_RIGHT];
              x_negative      <= b[HDR_XSIGN];
              y_negative      <= b[HDR_YSIGN];
              phase           <= PH_X;
            end
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/ps2mce_fifo.sv -----
// ----------------------------------------------------------------------------
// ps2mce_fifo
// Small packet queue between framing and event logic.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ps2_mouse_packet_and_click_events_unit_macros.svh"

module ps2mce_fifo #(
  parameter int DEPTH = 2
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push_valid,
  output logic              push_ready,
  input  ps2mce_pkg::pkt_t  push_data,
  output logic              pop_valid,
  input  wire               pop_ready,
  output ps2mce_pkg::pkt_t  pop_data
);
  import ps2mce_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  pkt_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `PS2MCE_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= FULL)
  `PS2MCE_ASSERT_NEXT(a_push_only_grows, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

`default_nettype wire

// ----- src/ps2mce_back.sv -----
// ----------------------------------------------------------------------------
// ps2mce_back
// Click event decision, cursor move and clamp, output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ps2_mouse_packet_and_click_events_unit_macros.svh"

module ps2mce_back (
  input  wire                                        clk,
  input  wire                                        rst,
  input  wire                                        cfg_write,
  input  wire [ps2mce_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  wire [ps2mce_pkg::CFG_DATA_BITS-1:0]        cfg_data,
  input  wire                                        pkt_valid,
  output logic                                       pkt_ready,
  input  ps2mce_pkg::pkt_t                           pkt,
  output logic                                       out_valid,
  input  wire                                        out_ready,
  output ps2mce_pkg::out_item_t                      out_item
);
  import ps2mce_pkg::*;

  localparam int SUM_W = COORD_BITS + 2;

  logic [COORD_BITS-1:0] x_limit;
  logic [COORD_BITS-1:0] y_limit;
  logic [WIN_BITS-1:0]   dclick_window;

  logic                  left_held;
  logic                  right_held;
  logic [TICK_BITS-1:0]  last_release_tick;
  logic                  release_recorded;
  event_t                previous_event;
  logic [COORD_BITS-1:0] position_x;
  logic [COORD_BITS-1:0] position_y;

  logic                  left_held_next;
  logic                  right_held_next;
  logic [TICK_BITS-1:0]  last_release_tick_next;
  logic                  release_recorded_next;
  event_t                ev;
  logic [COORD_BITS-1:0] position_x_next;
  logic [COORD_BITS-1:0] position_y_next;
  logic [TICK_BITS-1:0]  tick_diff;
  logic                  pop;

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SUM_W-1:0] v,
                                                   input logic [COORD_BITS-1:0] lim);
    logic signed [SUM_W-1:0] lim_s;
    lim_s = $signed({2'b00, lim});
    if (v < 0) begin
      return '0;
    end else if (v > lim_s) begin
      return lim;
    end else begin
      return v[COORD_BITS-1:0];
    end
  endfunction

  assign pkt_ready = !out_valid || out_ready;
  assign pop       = pkt_valid && pkt_ready;
  assign tick_diff = pkt.tick - last_release_tick;

  always_comb begin
    left_held_next         = left_held;
    right_held_next        = right_held;
    last_release_tick_next = last_release_tick;
    release_recorded_next  = release_recorded;
    ev                     = EV_NONE;
    if (pkt.left) begin
      if (!left_held) begin
        left_held_next = 1'b1;
      end else begin
        ev = EV_DRAG;
      end
    end else if (left_held) begin
      left_held_next = 1'b0;
      if (release_recorded && (tick_diff <= TICK_BITS'(dclick_window))) begin
        ev                    = EV_DOUBLE;
        release_recorded_next = 1'b0;
      end else begin
        ev                     = (previous_event == EV_DRAG) ? EV_NONE : EV_LEFT;
        release_recorded_next  = 1'b1;
        last_release_tick_next = pkt.tick;
      end
    end
    // right release overrides any left event
    if (pkt.right) begin
      right_held_next = 1'b1;
    end else if (right_held) begin
      right_held_next = 1'b0;
      ev              = EV_RIGHT;
    end
    position_x_next = clamp($signed({2'b00, position_x}) + SUM_W'(pkt.dx), x_limit);
    position_y_next = clamp($signed({2'b00, position_y}) + SUM_W'(pkt.dy), y_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit       <= WIDTH_RESET;
      y_limit       <= HEIGHT_RESET;
      dclick_window <= WINDOW_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_X_LIMIT:       x_limit       <= cfg_data[COORD_BITS-1:0];
        CFG_Y_LIMIT:       y_limit       <= cfg_data[COORD_BITS-1:0];
        CFG_DCLICK_WINDOW: dclick_window <= cfg_data[WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_held         <= 1'b0;
      right_held        <= 1'b0;
      last_release_tick <= '0;
      release_recorded  <= 1'b0;
      previous_event    <= EV_NONE;
      position_x        <= POS_X_RESET;
      position_y        <= POS_Y_RESET;
      out_valid         <= 1'b0;
    end else begin
      if (pop) begin
        left_held         <= left_held_next;
        right_held        <= right_held_next;
        last_release_tick <= last_release_tick_next;
        release_recorded  <= release_recorded_next;
        previous_event    <= ev;
        position_x        <= position_x_next;
        position_y        <= position_y_next;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.event_code <= ev;
      out_item.cursor_x   <= position_x_next;
      out_item.cursor_y   <= position_y_next;
    end
  end

  `PS2MCE_ASSERT_NEXT(a_pop_fills_out, clk, rst, pop, out_valid)
  `PS2MCE_ASSERT_NEXT(a_event_tracked, clk, rst, pop, previous_event == out_item.event_code)

endmodule

`default_nettype wire

// ----- src/ps2_mouse_packet_and_click_events_unit.sv -----
// PS/2 mouse packet decoder with click events.
// Input channel (in_valid/in_ready/in_item) carries one mouse byte per request,
// tagged with byte_ready and the current tick. A byte with byte_ready low
// restarts framing at the header. Bad headers (sync bit clear or middle
// button set) are dropped. Each complete header/X/Y packet gives one result
// on the output channel (out_valid/out_ready/out_item): the click event and
// the clamped cursor position. Header and X bytes give no result.
// Throughput: one byte per cycle unless a Y byte stalls on a full queue. A
// result passes the packet queue, then the output register, to out_valid.
// The framing front end stalls only on a Y byte while the packet queue is
// full; the queue fills when the receiver holds out_ready low, so a stalled
// receiver backs up to the input after QUEUE_DEPTH packets plus one result.
// Reset (rst, synchronous) restores framing to header expected, clears the
// button and release history, centers the cursor at 400,300 and loads the
// register defaults 800, 600, 30. Registers are written through cfg_write,
// cfg_index and cfg_data; the user must do so only while the unit is idle,
// which the unit does not enforce. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
// ps2_mouse_packet_and_click_events_unit
// Top level: framing front end, packet queue, event and cursor back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_and_click_events_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  ps2mce_pkg::in_item_t                in_item,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output ps2mce_pkg::out_item_t               out_item,
  input  wire                                 cfg_write,
  input  wire [ps2mce_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire [ps2mce_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import ps2mce_pkg::*;

  pkt_t front_pkt;
  logic front_valid;
  logic front_ready;
  pkt_t back_pkt;
  logic back_valid;
  logic back_ready;

  ps2mce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .pkt_valid (front_valid),
    .pkt_ready (front_ready),
    .pkt       (front_pkt)
  );

  ps2mce_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_pkt),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_pkt)
  );

  ps2mce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pkt_valid (back_valid),
    .pkt_ready (back_ready),
    .pkt       (back_pkt),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- test/ps2_mouse_packet_and_click_events_unit_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet unit: checker
// Watches the byte, result and register ports, keeps its own model of the
// packet framing, click history and cursor, and compares every result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module ps2_mouse_packet_and_click_events_unit_checker
  import ps2mce_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  input  wire                        in_ready,
  input  in_item_t                   in_item,
  input  wire                        out_valid,
  input  wire                        out_ready,
  input  out_item_t                  out_item,
  input  wire                        cfg_write,
  input  wire [CFG_IDX_BITS-1:0]     cfg_index,
  input  wire [CFG_DATA_BITS-1:0]    cfg_data,
  output int                         errors,
  output int                         pending,
  output int                         checked
);

  typedef enum logic [1:0] {
    FR_HEADER = 2'd0,
    FR_X      = 2'd1,
    FR_Y      = 2'd2
  } frame_t;

  // register copies
  logic [COORD_BITS-1:0] max_x;
  logic [COORD_BITS-1:0] max_y;
  logic [WIN_BITS-1:0]   dclick_win;

  // decoder state
  frame_t                frame;
  logic                  left_pkt;
  logic                  right_pkt;
  logic                  x_neg;
  logic                  y_neg;
  int                    x_step;
  logic                  left_held;
  logic                  right_held;
  logic [TICK_BITS-1:0]  last_release;
  logic                  release_seen;
  event_t                prev_event;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;

  out_item_t             expected_results[$];

  function automatic logic [COORD_BITS-1:0] fit_coord(input int v,
                                                     input logic [COORD_BITS-1:0] lim);
    if (v < 0) v = 0;
    if (v > int'(lim)) v = int'(lim);
    return v[COORD_BITS-1:0];
  endfunction

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("[%0t] %s", $time, msg);
  endtask

  task automatic take_byte(input in_item_t it);
    logic [7:0]           b;
    int                   y_raw;
    event_t               ev;
    logic [TICK_BITS-1:0] since;
    out_item_t            res;
    b = it.data_byte;
    if (!it.byte_ready) begin
      frame = FR_HEADER;
    end else if (frame == FR_X) begin
      x_step = int'(b) - (x_neg ? 256 : 0);
      frame = FR_Y;
    end else if (frame != FR_Y) begin
      frame = FR_HEADER;
      if (b[HDR_SYNC] && !b[HDR_MID]) begin
        left_pkt  = b[HDR_LEFT];
        right_pkt = b[HDR_RIGHT];
        x_neg     = b[HDR_XSIGN];
        y_neg     = b[HDR_YSIGN];
        frame     = FR_X;
      end
    end else begin
      frame = FR_HEADER;
      y_raw = int'(b) - (y_neg ? 256 : 0);
      ev = EV_NONE;
      if (left_pkt) begin
        if (!left_held) left_held = 1'b1;
        else ev = EV_DRAG;
      end else if (left_held) begin
        left_held = 1'b0;
        since = it.tick_now - last_release;
        if (release_seen && since <= TICK_BITS'(dclick_win)) ev = EV_DOUBLE;
        else if (prev_event == EV_DRAG) ev = EV_NONE;
        else ev = EV_LEFT;
        if (ev == EV_DOUBLE) begin
          release_seen = 1'b0;
        end else begin
          release_seen = 1'b1;
          last_release = it.tick_now;
        end
      end
      // a right release wins over whatever the left button did
      if (right_pkt) begin
        right_held = 1'b1;
      end else if (right_held) begin
        right_held = 1'b0;
        ev = EV_RIGHT;
      end
      prev_event = ev;
      pos_x = fit_coord(int'(pos_x) + x_step, max_x);
      pos_y = fit_coord(int'(pos_y) - y_raw, max_y);
      res.event_code = ev;
      res.cursor_x   = pos_x;
      res.cursor_y   = pos_y;
      expected_results.push_back(res);
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      max_x        = WIDTH_RESET;
      max_y        = HEIGHT_RESET;
      dclick_win   = WINDOW_RESET;
      frame        = FR_HEADER;
      left_pkt     = 1'b0;
      right_pkt    = 1'b0;
      x_neg        = 1'b0;
      y_neg        = 1'b0;
      x_step       = 0;
      left_held    = 1'b0;
      right_held   = 1'b0;
      last_release = '0;
      release_seen = 1'b0;
      prev_event   = EV_NONE;
      pos_x        = POS_X_RESET;
      pos_y        = POS_Y_RESET;
      expected_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_X_LIMIT:       max_x = cfg_data[COORD_BITS-1:0];
          CFG_Y_LIMIT:       max_y = cfg_data[COORD_BITS-1:0];
          CFG_DCLICK_WINDOW: dclick_win = cfg_data[WIN_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result with nothing expected: ev=%0d x=%0d y=%0d",
                                 out_item.event_code, out_item.cursor_x,
                                 out_item.cursor_y));
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (out_item.event_code !== want.event_code ||
              out_item.cursor_x !== want.cursor_x ||
              out_item.cursor_y !== want.cursor_y)
            note_failure($sformatf(
              "mismatch: expected ev=%0d x=%0d y=%0d, got ev=%0d x=%0d y=%0d",
              want.event_code, want.cursor_x, want.cursor_y,
              out_item.event_code, out_item.cursor_x, out_item.cursor_y));
        end
      end
      if (in_valid && in_ready) take_byte(in_item);
    end
    pending = expected_results.size();
  end

endmodule

// ----- test/ps2_mouse_packet_and_click_events_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PS/2 mouse packet unit: testbench top
// Drives mouse bytes and register writes, stalls the result side at random,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------

module ps2_mouse_packet_and_click_events_unit_tb;
  import ps2mce_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  in_item_t                 in_item;
  logic                     out_valid;
  logic                     out_ready;
  out_item_t                out_item;
  logic                     cfg_write;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  int errors;
  int pending;
  int checked;
  int cycles;
  int bytes_sent;
  int packets_sent;
  int settings_used;
  bit calm;

  // stimulus-side view of the button and release history
  logic                 cur_left;
  logic                 cur_right;
  logic [TICK_BITS-1:0] tick;
  logic [TICK_BITS-1:0] rel_tick;
  logic [WIN_BITS-1:0]  cur_win;

  ps2_mouse_packet_and_click_events_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ps2_mouse_packet_and_click_events_unit_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
    $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
    $display("** ps2_mouse_packet_and_click_events_unit: FAILED **");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [8:0] pick_move();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 9'($signed($urandom_range(0, 40)) - 20);
    if (r < 85) return 9'($signed($urandom_range(0, 255)) - 128);
    return 9'($signed($urandom_range(0, 511)) - 256);
  endfunction

  // result side: random stalls, except in calm stretches
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_ready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
    end
  end

  // called and returns at a falling edge
  task automatic put_byte(input logic rdy, input logic [7:0] b,
                          input logic [TICK_BITS-1:0] t);
    int       gap;
    in_item_t it;
    gap = calm ? 0 : pick_gap();
    it.byte_ready = rdy;
    it.data_byte  = b;
    it.tick_now   = t;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic put_packet(input logic lft, input logic rgt,
                            input logic signed [8:0] dx, input logic signed [8:0] dy,
                            input logic [TICK_BITS-1:0] t);
    logic [7:0] hdr;
    hdr = 8'($urandom);
    hdr[HDR_LEFT]  = lft;
    hdr[HDR_RIGHT] = rgt;
    hdr[HDR_MID]   = 1'b0;
    hdr[HDR_SYNC]  = 1'b1;
    hdr[HDR_XSIGN] = dx[8];
    hdr[HDR_YSIGN] = dy[8];
    put_byte(1'b1, hdr, $urandom);
    put_byte(1'b1, dx[7:0], $urandom);
    put_byte(1'b1, dy[7:0], t);
    packets_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    if (idx == CFG_DCLICK_WINDOW) cur_win = d;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // header and X bytes give no result, so allow the pipeline to empty too
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_traffic(input int n_bytes);
    int         r;
    int         sent;
    logic       releasing;
    sent = 0;
    while (sent < n_bytes) begin
      r = $urandom_range(0, 99);
      if (r < 84) begin
        if ($urandom_range(0, 99) < 35) cur_left = ~cur_left;
        if ($urandom_range(0, 99) < 12) cur_right = ~cur_right;
        releasing = !cur_left;
        r = $urandom_range(0, 99);
        if (releasing && r < 25) tick = rel_tick + cur_win + $urandom_range(0, 1);
        else if (r < 55) tick += $urandom_range(0, 40);
        else if (r < 80) tick += $urandom_range(0, 200);
        else if (r < 93) tick += $urandom_range(0, 70000);
        else tick = $urandom;
        if (releasing) rel_tick = tick;
        put_packet(cur_left, cur_right, pick_move(), pick_move(), tick);
        sent += 3;
      end else if (r < 92) begin
        // stray byte, usually followed by a framing reset
        put_byte(1'($urandom_range(0, 1)), 8'($urandom), $urandom);
        if ($urandom_range(0, 9) < 7) put_byte(1'b0, 8'($urandom), $urandom);
      end else begin
        // packet cut short by a byte that is not ready
        put_byte(1'b1, 8'(8'h08 | ($urandom & 8'hF3)), $urandom);
        if ($urandom_range(0, 1)) put_byte(1'b1, 8'($urandom), $urandom);
        put_byte(1'b0, 8'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_item       = '0;
    cfg_write     = 1'b0;
    cfg_index     = CFG_X_LIMIT;
    cfg_data      = '0;
    calm          = 1'b0;
    bytes_sent    = 0;
    packets_sent  = 0;
    settings_used = 1;
    cur_left      = 1'b0;
    cur_right     = 1'b0;
    cur_win       = WINDOW_RESET;
    tick          = $urandom;
    rel_tick      = tick;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: framing, bad headers, extreme moves and left, double and right clicks
    put_byte(1'b0, 8'hFF, tick);
    put_byte(1'b1, 8'h00, tick);
    put_byte(1'b1, 8'h0C, tick);
    put_packet(1'b1, 1'b0, 9'sd255, -9'sd256, tick);
    tick += 100;
    put_packet(1'b0, 1'b0, -9'sd256, 9'sd255, tick);
    tick += 5;
    put_packet(1'b1, 1'b0, 9'sd0, 9'sd0, tick);
    tick += 5;
    put_packet(1'b0, 1'b0, 9'sd1, -9'sd1, tick);
    put_byte(1'b1, 8'h38, tick);
    put_byte(1'b1, 8'h80, tick);
    put_byte(1'b0, 8'h00, tick);
    put_packet(1'b0, 1'b1, -9'sd1, 9'sd1, tick);
    put_packet(1'b1, 1'b0, 9'sd0, 9'sd0, tick);
    cur_left = 1'b1;

    for (int phase = 0; phase < 6; phase++) begin
      calm = ($urandom_range(0, 3) == 0);
      if (phase > 0) begin
        settle();
        settings_used++;
        case (phase)
          1: begin
            write_reg(CFG_X_LIMIT, 16'd1);
            write_reg(CFG_Y_LIMIT, 16'd1);
            write_reg(CFG_DCLICK_WINDOW, 16'd0);
            write_reg(CFG_UNUSED, 16'($urandom));
          end
          2: begin
            // upper bits of the data must be dropped
            write_reg(CFG_X_LIMIT, 16'hFFFF);
            write_reg(CFG_Y_LIMIT, 16'hF7FF);
            write_reg(CFG_DCLICK_WINDOW, 16'hFFFF);
          end
          4: begin
            write_reg(CFG_X_LIMIT, 16'd10);
            write_reg(CFG_Y_LIMIT, 16'd5);
            write_reg(CFG_DCLICK_WINDOW, 16'd1);
            write_reg(CFG_UNUSED, 16'd0);
          end
          default: begin
            write_reg(CFG_X_LIMIT, 16'($urandom_range(1, 2047)));
            write_reg(CFG_Y_LIMIT, 16'($urandom_range(1, 2047)));
            write_reg(CFG_DCLICK_WINDOW, 16'($urandom_range(0, 200)));
          end
        endcase
      end
      random_traffic((phase == 3 || phase == 5) ? 300 : 250);
    end

    settle();
    $display("sent %0d bytes (%0d full packets) under %0d register settings",
             bytes_sent, packets_sent, settings_used);
    $display("checked %0d results, %0d failures", checked, errors);
    if (errors == 0)
      $display("** ps2_mouse_packet_and_click_events_unit: PASSED **");
    else
      $display("** ps2_mouse_packet_and_click_events_unit: FAILED **");
    $finish;
  end

endmodule
